// ===== sv/cwsc_pkg.sv =====
`default_nettype none

package cwsc_pkg;

  localparam int unsigned WordW      = 16;
  localparam int unsigned ByteW      = 8;
  localparam int unsigned QueueDepth = 2;
  localparam int unsigned QueuePtrW  = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned QueueCntW  = $clog2(QueueDepth + 1);

  localparam logic [WordW-1:0] Poly   = 16'h8005;
  localparam logic [WordW-1:0] TopBit = 16'h8000;

  typedef enum logic [2:0] {
    OP_LOAD,
    OP_SHIFT,
    OP_EMIT_WORD,
    OP_EMIT_SHIFT,
    OP_EMIT_SHIFT2
  } op_e;

  typedef struct packed {
    op_e              kind;
    logic [WordW-1:0] word;
  } op_t;

  typedef logic [WordW-1:0][2*WordW-1:0] mask_t;

  function automatic logic [WordW-1:0] shift_word_f(input logic [WordW-1:0] reg_in,
                                                    input logic [WordW-1:0] word_in);
    logic [WordW-1:0] r;
    logic [WordW-1:0] w;
    logic             top;
    r = reg_in;
    w = word_in;
    for (int i = 0; i < WordW; i++) begin
      top = |(r & TopBit);
      r   = {r[WordW-2:0], w[WordW-1]};
      if (top) begin
        r = r ^ Poly;
      end
      w = {w[WordW-2:0], 1'b0};
    end
    return r;
  endfunction

  function automatic mask_t build_masks_f(input logic close_twice);
    mask_t              m;
    logic [2*WordW-1:0] vec;
    logic [WordW-1:0]   res;
    m = '0;
    for (int i = 0; i < 2*WordW; i++) begin
      vec = '0;
      vec[i] = 1'b1;
      res = shift_word_f(vec[2*WordW-1:WordW], vec[WordW-1:0]);
      if (close_twice) begin
        res = shift_word_f(res, '0);
      end
      for (int j = 0; j < WordW; j++) begin
        m[j][i] = res[j];
      end
    end
    return m;
  endfunction

  localparam mask_t ShiftMasks  = build_masks_f(1'b0);
  localparam mask_t Shift2Masks = build_masks_f(1'b1);

  function automatic logic [WordW-1:0] apply_masks_f(input mask_t m,
                                                     input logic [2*WordW-1:0] vec);
    logic [WordW-1:0] res;
    for (int j = 0; j < WordW; j++) begin
      res[j] = ^(m[j] & vec);
    end
    return res;
  endfunction

endpackage

`default_nettype wire

// ===== sv/cwsc_front.sv =====
`default_nettype none

module cwsc_front (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       in_valid_i,
  output logic                            in_ready_o,
  input  wire logic [cwsc_pkg::ByteW-1:0] in_byte_i,
  input  wire logic                       in_last_i,
  input  wire logic                       q_full_i,
  output logic                            push_o,
  output cwsc_pkg::op_t                   push_op_o
);

  typedef enum logic [1:0] {
    PH_EMPTY,
    PH_ONE,
    PH_EVEN,
    PH_ODD
  } phase_e;

  phase_e                       phase_q, phase_d;
  logic [cwsc_pkg::ByteW-1:0]   held_q, held_d;
  logic [cwsc_pkg::WordW-1:0]   pair;
  logic                         accept;
  logic                         want_push;

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && in_ready_o;
  assign pair       = {held_q, in_byte_i};
  assign push_o     = accept && want_push;

  always_comb begin
    phase_d        = phase_q;
    held_d         = held_q;
    want_push      = 1'b0;
    push_op_o.kind = cwsc_pkg::OP_EMIT_WORD;
    push_op_o.word = '0;
    case (phase_q)
      PH_EMPTY: begin
        if (in_last_i) begin
          want_push = 1'b1;
        end else begin
          held_d  = in_byte_i;
          phase_d = PH_ONE;
        end
      end
      PH_ONE: begin
        want_push      = 1'b1;
        push_op_o.word = pair;
        push_op_o.kind = in_last_i ? cwsc_pkg::OP_EMIT_WORD : cwsc_pkg::OP_LOAD;
        phase_d        = PH_EVEN;
      end
      PH_EVEN: begin
        if (in_last_i) begin
          want_push      = 1'b1;
          push_op_o.kind = cwsc_pkg::OP_EMIT_SHIFT;
          push_op_o.word = {in_byte_i, {cwsc_pkg::ByteW{1'b0}}};
        end else begin
          held_d  = in_byte_i;
          phase_d = PH_ODD;
        end
      end
      PH_ODD: begin
        want_push      = 1'b1;
        push_op_o.word = pair;
        push_op_o.kind = in_last_i ? cwsc_pkg::OP_EMIT_SHIFT2 : cwsc_pkg::OP_SHIFT;
        phase_d        = PH_EVEN;
      end
      default: begin
        phase_d = PH_EMPTY;
      end
    endcase
    if (in_last_i) begin
      phase_d = PH_EMPTY;
      held_d  = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_EMPTY;
      held_q  <= '0;
    end else if (accept) begin
      phase_q <= phase_d;
      held_q  <= held_d;
    end
  end

`ifndef SYNTH
  a_last_ends_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && in_last_i) |=> (phase_q == PH_EMPTY))
    else $error("phase not cleared after last word");
`endif

endmodule

`default_nettype wire

// ===== sv/cwsc_queue.sv =====
`default_nettype none

module cwsc_queue (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push_i,
  input  wire cwsc_pkg::op_t push_op_i,
  output logic               full_o,
  input  wire logic          pop_i,
  output logic               valid_o,
  output cwsc_pkg::op_t      pop_op_o
);

  cwsc_pkg::op_t                      mem_q [cwsc_pkg::QueueDepth];
  logic [cwsc_pkg::QueuePtrW-1:0]     wr_ptr_q, rd_ptr_q;
  logic [cwsc_pkg::QueueCntW-1:0]     cnt_q;

  assign full_o   = (cnt_q == cwsc_pkg::QueueCntW'(cwsc_pkg::QueueDepth));
  assign valid_o  = (cnt_q != '0);
  assign pop_op_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_op_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == cwsc_pkg::QueuePtrW'(cwsc_pkg::QueueDepth - 1)) ?
                    '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == cwsc_pkg::QueuePtrW'(cwsc_pkg::QueueDepth - 1)) ?
                    '0 : rd_ptr_q + 1'b1;
      end
      cnt_q <= cnt_q + cwsc_pkg::QueueCntW'(push_i) - cwsc_pkg::QueueCntW'(pop_i);
    end
  end

`ifndef SYNTH
  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o)
    else $error("push into full queue");
  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> valid_o)
    else $error("pop from empty queue");
`endif

endmodule

`default_nettype wire

// ===== sv/cwsc_back.sv =====
`default_nettype none

module cwsc_back (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         op_valid_i,
  input  wire cwsc_pkg::op_t                op_i,
  output logic                              pop_o,
  output logic                              out_valid_o,
  input  wire logic                         out_ready_i,
  output logic [cwsc_pkg::WordW-1:0]        out_data_o
);

  logic [cwsc_pkg::WordW-1:0] reg_q, reg_d;
  logic [cwsc_pkg::WordW-1:0] result;
  logic                       out_valid_q;
  logic [cwsc_pkg::WordW-1:0] out_data_q;
  logic                       is_emit;
  logic                       out_free;

  assign is_emit     = op_i.kind inside {cwsc_pkg::OP_EMIT_WORD, cwsc_pkg::OP_EMIT_SHIFT,
                                         cwsc_pkg::OP_EMIT_SHIFT2};
  assign out_free    = !out_valid_q || out_ready_i;
  assign pop_o       = op_valid_i && (!is_emit || out_free);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  always_comb begin
    reg_d  = reg_q;
    result = '0;
    case (op_i.kind)
      cwsc_pkg::OP_LOAD: begin
        reg_d = op_i.word;
      end
      cwsc_pkg::OP_SHIFT: begin
        reg_d = cwsc_pkg::apply_masks_f(cwsc_pkg::ShiftMasks, {reg_q, op_i.word});
      end
      cwsc_pkg::OP_EMIT_WORD: begin
        result = op_i.word;
        reg_d  = '0;
      end
      cwsc_pkg::OP_EMIT_SHIFT: begin
        result = cwsc_pkg::apply_masks_f(cwsc_pkg::ShiftMasks, {reg_q, op_i.word});
        reg_d  = '0;
      end
      cwsc_pkg::OP_EMIT_SHIFT2: begin
        result = cwsc_pkg::apply_masks_f(cwsc_pkg::Shift2Masks, {reg_q, op_i.word});
        reg_d  = '0;
      end
      default: begin
        reg_d = reg_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      reg_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (pop_o) begin
        reg_q <= reg_d;
      end
      if (pop_o && is_emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o && is_emit) begin
      out_data_q <= result;
    end
  end

`ifndef SYNTH
  a_emit_clears_reg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop_o && is_emit) |=> (reg_q == '0))
    else $error("check register not cleared after result");
  a_emit_sets_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop_o && is_emit) |=> out_valid_q)
    else $error("result not presented");
`endif

endmodule

`default_nettype wire

// ===== sv/crc16_word_shift_checker_top.sv =====
// Path: a closing byte's op is written into the op queue; the back end registers its check value for output.
// Throughput: one byte per cycle while the op queue is not full; the word shift is a single XOR network per op.
// The two-entry op queue between pairing front and shift back sets stall decoupling.
// Reset: rst_ni asynchronous active low; clears phase, check register, queue, output valid.
`default_nettype none

module crc16_word_shift_checker_top (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [7:0]  s_axis_tdata_i,   // [7:0] data_byte
  input  wire logic        s_axis_tlast_i,
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output logic [15:0]      m_axis_tdata_o    // [15:0] check_value
);

  logic          q_full;
  logic          push;
  cwsc_pkg::op_t push_op;
  logic          pop;
  logic          op_valid;
  cwsc_pkg::op_t pop_op;

  cwsc_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .in_byte_i  (s_axis_tdata_i),
    .in_last_i  (s_axis_tlast_i),
    .q_full_i   (q_full),
    .push_o     (push),
    .push_op_o  (push_op)
  );

  cwsc_queue u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (push),
    .push_op_i (push_op),
    .full_o    (q_full),
    .pop_i     (pop),
    .valid_o   (op_valid),
    .pop_op_o  (pop_op)
  );

  cwsc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .op_valid_i  (op_valid),
    .op_i        (pop_op),
    .pop_o       (pop),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_data_o  (m_axis_tdata_o)
  );

endmodule

`default_nettype wire
